### hw/rtl/inferred_radix_word_to_integer_core_assert.svh
// Assertion macros used by the checker file of the radix word converter.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef INFERRED_RADIX_WORD_TO_INTEGER_CORE_ASSERT_SVH
`define INFERRED_RADIX_WORD_TO_INTEGER_CORE_ASSERT_SVH

// Checked at every edge outside reset.
`define IRWTI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define IRWTI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/irwti_pkg.sv
// Package of the radix word converter: sizes, character codes, token and state types.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package irwti_pkg;

  localparam int MAX_WORD   = 32;
  localparam int LEN_W      = $clog2(MAX_WORD + 2);
  localparam int ADDR_W     = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CODE_W     = 8;
  localparam int DIGIT_W    = 6;
  localparam int RADIX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CODE_W-1:0]  CH_SPACE  = 8'h20;
  localparam logic [CODE_W-1:0]  CH_NL     = 8'h0a;
  localparam logic [CODE_W-1:0]  CH_MINUS  = 8'h2d;
  localparam logic [CODE_W-1:0]  CH_0      = 8'h30;
  localparam logic [CODE_W-1:0]  CH_9      = 8'h39;
  localparam logic [CODE_W-1:0]  CH_UA     = 8'h41;
  localparam logic [CODE_W-1:0]  CH_UZ     = 8'h5a;
  localparam logic [CODE_W-1:0]  CH_LA     = 8'h61;
  localparam logic [CODE_W-1:0]  CH_LZ     = 8'h7a;
  localparam logic [CODE_W-1:0]  DIGIT_OFS = 8'd10;
  localparam logic [CODE_W-1:0]  BASE_OFS  = 8'd11;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  typedef enum logic [STATUS_W-1:0] {
    STAT_VALID,
    STAT_BAD_CHAR,
    STAT_NO_BASE,
    STAT_TOO_LONG
  } status_t;

  typedef enum logic {
    S_COLLECT,
    S_CALC
  } state_t;

  typedef struct packed {
    logic                delim;
    logic                alnum;
    logic                minus;
    logic [DIGIT_W-1:0]  digit;
    logic [CODE_W-1:0]   code;
  } token_t;

  function automatic logic [RADIX_W-1:0] base_of(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] t;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0 + 8'd1;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + BASE_OFS;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + BASE_OFS;
    end
    return t[RADIX_W-1:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] t;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + DIGIT_OFS;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + DIGIT_OFS;
    end
    return t[DIGIT_W-1:0];
  endfunction

endpackage

### hw/rtl/inferred_radix_word_to_integer_core.sv
// Top level of the radix-inferring word-to-integer converter.
// Depends on irwti_pkg, irwti_front, irwti_fifo and irwti_back.
//
//   channel   direction  handshake          payload
//   input     in         push / full        char_byte
//   result    out        empty / pop        status, radix, is_negative, value
//
// Bytes of a word are taken while the token queue has room. At a word's end the Horner pass
// reads the digit memory through its registered port, one digit a cycle; a word that
// fails a check gets its result without that pass.
// Bytes keep arriving into a four-entry token queue during that pass.
// A result waits in the output register until popped; a new word end holds
// the back until that register is free. Reset is synchronous and empties all.
`timescale 1ns / 1ps

module inferred_radix_word_to_integer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [irwti_pkg::CODE_W-1:0]          char_byte,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [irwti_pkg::STATUS_W-1:0]        status,
  output logic [irwti_pkg::RADIX_W-1:0]         radix,
  output logic                                  is_negative,
  output logic signed [irwti_pkg::VALUE_W-1:0]  value
);
  import irwti_pkg::*;

  logic   q_wr;
  token_t q_tok;
  logic   q_full;
  logic   q_avail;
  token_t q_head;
  logic   q_pop;
  logic   res_valid;

  irwti_front u_front (
    .push      (push),
    .full      (full),
    .char_byte (char_byte),
    .q_wr      (q_wr),
    .q_tok     (q_tok),
    .q_full    (q_full)
  );

  irwti_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_tok (q_tok),
    .full   (q_full),
    .rd_en  (q_pop),
    .avail  (q_avail),
    .rd_tok (q_head)
  );

  irwti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_avail  (q_avail),
    .tok        (q_head),
    .tok_pop    (q_pop),
    .res_pop    (pop && res_valid),
    .res_valid  (res_valid),
    .res_status (status),
    .res_radix  (radix),
    .res_neg    (is_negative),
    .res_value  (value)
  );

  assign empty = !res_valid;

endmodule

### hw/rtl/irwti_fifo.sv
// Short token queue between the classifying front and the converting back.
// Depends on irwti_pkg for the token type and queue depth.
`timescale 1ns / 1ps

module irwti_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  irwti_pkg::token_t wr_tok,
  output logic              full,
  input  logic              rd_en,
  output logic              avail,
  output irwti_pkg::token_t rd_tok
);
  import irwti_pkg::*;

  token_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full   = (count == FIFO_CW'(FIFO_DEPTH));
  assign avail  = (count != '0);
  assign rd_tok = slots[rd_ptr];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

endmodule

### hw/rtl/irwti_front.sv
// Input side: takes text bytes and turns each into a classified token.
// Depends on irwti_pkg for the token type and character codes.
`timescale 1ns / 1ps

module irwti_front (
  input  logic                          push,
  output logic                          full,
  input  logic [irwti_pkg::CODE_W-1:0]  char_byte,
  output logic                          q_wr,
  output irwti_pkg::token_t             q_tok,
  input  logic                          q_full
);
  import irwti_pkg::*;

  logic is_digit;
  logic is_upper;
  logic is_lower;

  assign is_digit = (char_byte >= CH_0) && (char_byte <= CH_9);
  assign is_upper = (char_byte >= CH_UA) && (char_byte <= CH_UZ);
  assign is_lower = (char_byte >= CH_LA) && (char_byte <= CH_LZ);

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_tok.delim = (char_byte == CH_SPACE) || (char_byte == CH_NL);
    q_tok.alnum = is_digit || is_upper || is_lower;
    q_tok.minus = (char_byte == CH_MINUS);
    q_tok.digit = digit_of(char_byte);
    q_tok.code  = char_byte;
  end

endmodule

### hw/rtl/irwti_back.sv
// Conversion side: gathers word digits, then Horner-converts each valid word.
// Depends on irwti_pkg for sizes, status codes, states and the base function.
`timescale 1ns / 1ps

module irwti_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tok_avail,
  input  irwti_pkg::token_t               tok,
  output logic                            tok_pop,
  input  logic                            res_pop,
  output logic                            res_valid,
  output logic [irwti_pkg::STATUS_W-1:0]  res_status,
  output logic [irwti_pkg::RADIX_W-1:0]   res_radix,
  output logic                            res_neg,
  output logic signed [irwti_pkg::VALUE_W-1:0] res_value
);
  import irwti_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [LEN_W-1:0]    len;
  logic [CODE_W-1:0]   hi_code;
  logic                minus_seen;
  logic                bad_seen;
  logic                in_word;
  logic [DIGIT_W-1:0]  mem [MAX_WORD];
  logic [DIGIT_W-1:0]  rd_data;
  logic [LEN_W-1:0]    idx;
  logic                pend;
  logic [VALUE_W-1:0]  acc;
  logic [RADIX_W-1:0]  base;

  logic [RADIX_W-1:0]  eval_base;
  status_t             eval_status;
  logic                res_free;
  logic                idx_lt;
  logic                do_store;
  logic                do_start;
  logic                do_fin_err;
  logic                calc_done;

  assign eval_base = base_of(hi_code);
  assign res_free  = !res_valid || res_pop;
  assign idx_lt    = (idx < len);

  always_comb begin
    if (bad_seen) begin
      eval_status = STAT_BAD_CHAR;
    end else if (eval_base == '0 || eval_base > RADIX_MAX) begin
      eval_status = STAT_NO_BASE;
    end else if (len > LEN_W'(MAX_WORD)) begin
      eval_status = STAT_TOO_LONG;
    end else begin
      eval_status = STAT_VALID;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT: begin
        if (do_start) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (calc_done) begin
          state_next = S_COLLECT;
        end
      end
      default: state_next = S_COLLECT;
    endcase
  end

  always_comb begin
    tok_pop    = 1'b0;
    do_store   = 1'b0;
    do_start   = 1'b0;
    do_fin_err = 1'b0;
    calc_done  = 1'b0;
    unique case (state)
      S_COLLECT: begin
        if (tok_avail) begin
          if (!tok.delim) begin
            tok_pop  = 1'b1;
            do_store = 1'b1;
          end else if (!in_word) begin
            tok_pop = 1'b1;
          end else if (res_free) begin
            tok_pop    = 1'b1;
            do_start   = (eval_status == STAT_VALID);
            do_fin_err = (eval_status != STAT_VALID);
          end
        end
      end
      S_CALC: begin
        calc_done = !pend && !idx_lt;
      end
      default: begin
        calc_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      len        <= '0;
      hi_code    <= '0;
      minus_seen <= 1'b0;
      bad_seen   <= 1'b0;
      in_word    <= 1'b0;
      pend       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (do_store) begin
        if (tok.code > hi_code) begin
          hi_code <= tok.code;
        end
        if (tok.minus && len == '0) begin
          minus_seen <= 1'b1;
        end else if (!tok.alnum) begin
          bad_seen <= 1'b1;
        end
        if (len <= LEN_W'(MAX_WORD)) begin
          len <= len + 1'b1;
        end
        in_word <= 1'b1;
      end
      if (do_fin_err || calc_done) begin
        len        <= '0;
        hi_code    <= '0;
        minus_seen <= 1'b0;
        bad_seen   <= 1'b0;
        in_word    <= 1'b0;
      end
      if (do_start) begin
        pend <= 1'b0;
      end else if (state == S_CALC && !calc_done) begin
        pend <= idx_lt;
      end
      if (do_fin_err || calc_done) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      idx  <= minus_seen ? LEN_W'(1) : '0;
      acc  <= '0;
      base <= eval_base;
    end else if (state == S_CALC && !calc_done) begin
      if (idx_lt) begin
        idx <= idx + 1'b1;
      end
      if (pend) begin
        acc <= acc * VALUE_W'(base) + VALUE_W'(rd_data);
      end
    end
    if (do_fin_err) begin
      res_status <= eval_status;
      res_radix  <= '0;
      res_neg    <= 1'b0;
      res_value  <= '0;
    end else if (calc_done) begin
      res_status <= STAT_VALID;
      res_radix  <= base;
      res_neg    <= minus_seen;
      res_value  <= minus_seen ? (VALUE_W'(0) - acc) : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (do_store && len < LEN_W'(MAX_WORD)) begin
      mem[len[ADDR_W-1:0]] <= tok.digit;
    end
    rd_data <= mem[idx[ADDR_W-1:0]];
  end

endmodule

### hw/rtl/irwti_checker.sv
// Port-level checks of the radix word converter, bound to its top level.
// Depends on irwti_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "inferred_radix_word_to_integer_core_assert.svh"

module irwti_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  push,
  input logic                                  full,
  input logic [irwti_pkg::CODE_W-1:0]          char_byte,
  input logic                                  empty,
  input logic                                  pop,
  input logic [irwti_pkg::STATUS_W-1:0]        status,
  input logic [irwti_pkg::RADIX_W-1:0]         radix,
  input logic                                  is_negative,
  input logic signed [irwti_pkg::VALUE_W-1:0]  value
);
  import irwti_pkg::*;

  `IRWTI_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "Result present after reset.")
  `IRWTI_ASSERT(a_hold, clk, rst, !empty && !pop |=> !empty && $stable(value), "Stalled result changed.")
  `IRWTI_ASSERT(a_err_zero, clk, rst, !empty && status != STAT_VALID |-> radix == '0 && value == '0 && !is_negative, "Failed transaction carries data.")
  `IRWTI_ASSERT(a_radix_range, clk, rst, !empty && status == STAT_VALID |-> radix != '0 && radix <= RADIX_MAX, "Valid transaction has a base out of range.")

endmodule

bind inferred_radix_word_to_integer_core irwti_checker u_checker (.*);
